// File: src/srm_pkg.sv
// shared types, widths and constants of the step response metrics unit
`default_nettype none

package srm_pkg;

  // field widths
  localparam int SPEED_W    = 16;
  localparam int TIME_W     = 32;
  localparam int ERR_W      = 17;
  localparam int BAND_W     = 7;
  localparam int MIN_TIME_W = 16;
  localparam int OVS_W      = 16;
  localparam int MEAN_W     = 16;

  // stream payload widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_USER_W = 4;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_SETPOINT = 2'd0;
  localparam logic [1:0] REG_BAND     = 2'd1;
  localparam logic [1:0] REG_MIN_TIME = 2'd2;
  localparam logic [SPEED_W-1:0]    SETPOINT_RST = 16'd0;
  localparam logic [BAND_W-1:0]     BAND_RST     = 7'd5;
  localparam logic [MIN_TIME_W-1:0] MIN_TIME_RST = 16'd200;

  // threshold scaling
  localparam int RISE_PROD_W   = 20;
  localparam int BAND_PROD_W   = 24;
  localparam int RISE_LO_SCALE = 10;
  localparam int RISE_HI_SCALE = 9;
  localparam int BAND_SCALE    = 100;
  localparam int OVS_SCALE     = 10000;

  // shared divider
  localparam int OVS_DIVIDEND_W = 29;
  localparam int DIVISOR_W      = 16;

  localparam int WINDOW_LEN_DEF = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_PREP,
    ST_PROD,
    ST_EVAL,
    ST_OVS_LOAD,
    ST_OVS_GO,
    ST_OVS_WAIT,
    ST_MEAN_LOAD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_DONE
  } srm_state_t;

  typedef struct packed {
    logic [SPEED_W-1:0]    setpoint;
    logic [BAND_W-1:0]     band_pct;
    logic [MIN_TIME_W-1:0] min_time;
  } srm_cfg_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic prep;
    logic prod;
    logic eval;
    logic ovs_load;
    logic mean_load;
    logic div_start;
    logic ovs_store;
    logic mean_store;
    logic load_out;
  } srm_cmd_t;

  typedef struct packed {
    logic in_mode;
    logic active;
    logic ovs_due;
    logic div_done;
    logic out_busy;
    logic mean_by_div;
  } srm_sts_t;

endpackage

`default_nettype wire

// File: src/step_response_metrics_unit.sv
// top level of the step response metrics unit
//
// usage: write setpoint, settle band percent and settle minimum time through
// the apb port while the unit is idle, then stream items on the s_ side.
// an item with tuser mode set starts a step and latches its timestamp; later
// sample items update the rise, settle, peak and error-window measurements.
// every transfer in gives exactly one transfer out on the m_ side carrying
// the metrics as they stand after that item.
// flow: one item at a time. a start item steps through capture, start and output
// load; a sample before any start goes from capture to output load; a measured
// sample steps through capture, magnitudes and window read, scaling products,
// evaluate, output load. when the window length is not a power of two the mean
// comes from the shared divider; the one sample that completes the metrics also
// runs the overshoot division, one quotient bit per cycle.
// reset clears all measurement state and the error window valid bits at once
// and loads the register defaults; no clearing pass is needed.
// stall: a result waits in the output register while the next item is taken
// and processed; the unit holds in its final step until the register frees.
`default_nettype none

module step_response_metrics_unit
  import srm_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // measured_speed, time_ms
  input  wire logic [IN_USER_W-1:0]  s_tuser,   // mode
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,   // rise_time, settling_time, overshoot,
                                                // mean_abs_error
  output logic      [OUT_USER_W-1:0] m_tuser    // step_running, rise_found, settle_found,
                                                // metrics_ready
);

  srm_cfg_t cfg;
  srm_cmd_t cmd;
  srm_sts_t sts;

  // register file
  srm_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // sequencer: takes an item only when idle, steps the datapath
  srm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // measurement state, error window and output register
  srm_datapath #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cmd     (cmd),
    .sts     (sts),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

`default_nettype wire

// File: src/srm_cfg_regs.sv
// apb-style configuration registers
`default_nettype none

module srm_cfg_regs
  import srm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output srm_cfg_t                   cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint <= SETPOINT_RST;
      cfg.band_pct <= BAND_RST;
      cfg.min_time <= MIN_TIME_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SETPOINT: cfg.setpoint <= pwdata[SPEED_W-1:0];
        REG_BAND:     cfg.band_pct <= pwdata[BAND_W-1:0];
        REG_MIN_TIME: cfg.min_time <= pwdata[MIN_TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SETPOINT: prdata = CFG_DATA_W'(cfg.setpoint);
      REG_BAND:     prdata = CFG_DATA_W'(cfg.band_pct);
      REG_MIN_TIME: prdata = CFG_DATA_W'(cfg.min_time);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/srm_divider.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module srm_divider #(
  parameter int DIVIDEND_W = 29,
  parameter int DIVISOR_W  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic      [DIVIDEND_W-1:0] quotient,
  output logic                       done
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  assign shifted = {rem, quotient[DIVIDEND_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: src/srm_ctrl.sv
// sequencing state machine of the step response metrics unit
`default_nettype none

module srm_ctrl
  import srm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  input  wire srm_sts_t sts,
  output srm_cmd_t      cmd
);

  srm_state_t state;
  srm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (sts.in_mode)     state_next = ST_START;
          else if (sts.active) state_next = ST_PREP;
          else                 state_next = ST_DONE;
        end
      end
      ST_START: state_next = ST_DONE;
      ST_PREP:  state_next = ST_PROD;
      ST_PROD:  state_next = ST_EVAL;
      ST_EVAL: begin
        if (sts.ovs_due)          state_next = ST_OVS_LOAD;
        else if (sts.mean_by_div) state_next = ST_MEAN_LOAD;
        else                      state_next = ST_DONE;
      end
      ST_OVS_LOAD: state_next = ST_OVS_GO;
      ST_OVS_GO:   state_next = ST_OVS_WAIT;
      ST_OVS_WAIT: begin
        if (sts.div_done) state_next = sts.mean_by_div ? ST_MEAN_LOAD : ST_DONE;
      end
      ST_MEAN_LOAD: state_next = ST_MEAN_GO;
      ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (sts.div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      ST_START:     cmd.start = 1'b1;
      ST_PREP:      cmd.prep = 1'b1;
      ST_PROD:      cmd.prod = 1'b1;
      ST_EVAL:      cmd.eval = 1'b1;
      ST_OVS_LOAD:  cmd.ovs_load = 1'b1;
      ST_OVS_GO:    cmd.div_start = 1'b1;
      ST_OVS_WAIT:  cmd.ovs_store = sts.div_done;
      ST_MEAN_LOAD: cmd.mean_load = 1'b1;
      ST_MEAN_GO:   cmd.div_start = 1'b1;
      ST_MEAN_WAIT: cmd.mean_store = sts.div_done;
      ST_DONE:      cmd.load_out = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: src/srm_datapath.sv
// measurement state, error window memory, divider and output register
`default_nettype none

module srm_datapath
  import srm_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire srm_cfg_t              cfg,
  input  wire srm_cmd_t              cmd,
  output srm_sts_t                   sts,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic [IN_USER_W-1:0]  s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,
  output logic      [OUT_USER_W-1:0] m_tuser
);

  localparam int   SLOT_W   = $clog2(WINDOW_LEN);
  localparam int   TOT_W    = ERR_W + SLOT_W;
  localparam int   DIV_W    = (TOT_W > OVS_DIVIDEND_W) ? TOT_W : OVS_DIVIDEND_W;
  localparam logic WIN_POW2 = ((WINDOW_LEN & (WINDOW_LEN - 1)) == 0);

  // captured item and per-sample operands
  logic [SPEED_W-1:0]     meas_r;
  logic [TIME_W-1:0]      time_r;
  logic [SPEED_W-1:0]     asp_r;
  logic [SPEED_W-1:0]     am_r;
  logic [ERR_W-1:0]       err_r;
  logic [ERR_W-1:0]       old_r;
  logic                   old_vld;
  logic [RISE_PROD_W-1:0] am10;
  logic [RISE_PROD_W-1:0] asp9;
  logic [BAND_PROD_W-1:0] err100;
  logic [BAND_PROD_W-1:0] band_lim;

  // measurement state
  logic               active_flag;
  logic [TIME_W-1:0]  start_stamp;
  logic               rise_begun;
  logic [TIME_W-1:0]  rise_begin_stamp;
  logic               rise_measured;
  logic [TIME_W-1:0]  rise_duration;
  logic               in_band;
  logic [TIME_W-1:0]  band_entry_stamp;
  logic               settle_measured;
  logic [TIME_W-1:0]  settle_duration;
  logic [SPEED_W-1:0] peak;
  logic [SLOT_W-1:0]  window_slot;
  logic [TOT_W-1:0]   window_total;
  logic [OVS_W-1:0]   overshoot_value;
  logic [MEAN_W-1:0]  mean_value;
  logic               ready_flag;

  logic [ERR_W-1:0]      win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] win_vld;

  // divider operands
  logic [DIV_W-1:0]     div_a;
  logic [DIVISOR_W-1:0] div_b;
  logic [DIV_W-1:0]     div_quo;
  logic                 div_done;

  // combinational sample terms
  logic [SPEED_W-1:0] sp_mag;
  logic [SPEED_W-1:0] meas_mag;
  logic [ERR_W-1:0]   diff;
  logic [ERR_W-1:0]   diff_mag;
  logic               rise_lo;
  logic               rise_hi;
  logic               rise_complete;
  logic [TIME_W-1:0]  rise_stamp_eff;
  logic               settle_check;
  logic               band_hit;
  logic [TIME_W-1:0]  band_stamp_eff;
  logic               settle_complete;
  logic [ERR_W-1:0]   old_err;
  logic [TOT_W-1:0]   total_next;
  logic [SPEED_W-1:0] peak_next;
  logic [SPEED_W-1:0] ovs_diff;
  logic               ovs_due;

  always_comb begin
    sp_mag   = cfg.setpoint[SPEED_W-1] ? SPEED_W'(~cfg.setpoint + 1'b1) : cfg.setpoint;
    meas_mag = meas_r[SPEED_W-1] ? SPEED_W'(~meas_r + 1'b1) : meas_r;
    diff     = {meas_r[SPEED_W-1], meas_r} - {cfg.setpoint[SPEED_W-1], cfg.setpoint};
    diff_mag = diff[ERR_W-1] ? ERR_W'(~diff + 1'b1) : diff;
  end

  always_comb begin
    rise_lo         = am10 >= RISE_PROD_W'(asp_r);
    rise_hi         = am10 >= asp9;
    rise_stamp_eff  = rise_begun ? rise_begin_stamp : time_r;
    rise_complete   = !rise_measured && (rise_begun || rise_lo) && rise_hi;
    settle_check    = !settle_measured && (asp_r != '0);
    band_hit        = err100 <= band_lim;
    band_stamp_eff  = in_band ? band_entry_stamp : time_r;
    settle_complete = settle_check && band_hit &&
                      ((time_r - band_stamp_eff) >= TIME_W'(cfg.min_time));
    old_err         = old_vld ? old_r : '0;
    total_next      = window_total - TOT_W'(old_err) + TOT_W'(err_r);
    peak_next       = (am_r > peak) ? am_r : peak;
    ovs_diff        = peak - asp_r;
    ovs_due         = (rise_measured || rise_complete) &&
                      (settle_measured || settle_complete) && !ready_flag;
  end

  // operand pipeline, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas_r <= s_tdata[SPEED_W-1:0];
      time_r <= s_tdata[SPEED_W +: TIME_W];
    end
    if (cmd.prep) begin
      asp_r <= sp_mag;
      am_r  <= meas_mag;
      err_r <= diff_mag;
    end
    if (cmd.prod) begin
      am10     <= RISE_PROD_W'(am_r) * RISE_PROD_W'(RISE_LO_SCALE);
      asp9     <= RISE_PROD_W'(asp_r) * RISE_PROD_W'(RISE_HI_SCALE);
      err100   <= BAND_PROD_W'(err_r) * BAND_PROD_W'(BAND_SCALE);
      band_lim <= BAND_PROD_W'(asp_r) * BAND_PROD_W'(cfg.band_pct);
    end
    if (cmd.ovs_load) begin
      if ((asp_r != '0) && (peak > asp_r)) begin
        div_a <= DIV_W'(ovs_diff * OVS_SCALE);
        div_b <= asp_r;
      end else begin
        div_a <= '0;
        div_b <= DIVISOR_W'(1);
      end
    end else if (cmd.mean_load) begin
      div_a <= DIV_W'(window_total);
      div_b <= DIVISOR_W'(WINDOW_LEN);
    end
  end

  // error window memory
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      old_r <= win_mem[window_slot];
    end
    if (cmd.eval) begin
      win_mem[window_slot] <= err_r;
    end
  end

  // measurement state
  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      active_flag      <= cmd.start & ~rst;
      start_stamp      <= (cmd.start & ~rst) ? time_r : '0;
      rise_begun       <= 1'b0;
      rise_begin_stamp <= '0;
      rise_measured    <= 1'b0;
      rise_duration    <= '0;
      in_band          <= 1'b0;
      band_entry_stamp <= '0;
      settle_measured  <= 1'b0;
      settle_duration  <= '0;
      peak             <= '0;
      win_vld          <= '0;
      window_slot      <= '0;
      window_total     <= '0;
      overshoot_value  <= '0;
      mean_value       <= '0;
      ready_flag       <= 1'b0;
      old_vld          <= 1'b0;
    end else begin
      if (cmd.prep) begin
        old_vld <= win_vld[window_slot];
      end
      if (cmd.eval) begin
        peak <= peak_next;
        if (!rise_measured) begin
          if (!rise_begun && rise_lo) begin
            rise_begun       <= 1'b1;
            rise_begin_stamp <= time_r;
          end
          if (rise_complete) begin
            rise_duration <= time_r - rise_stamp_eff;
            rise_measured <= 1'b1;
          end
        end
        if (settle_check) begin
          if (band_hit) begin
            in_band          <= 1'b1;
            band_entry_stamp <= band_stamp_eff;
            if (settle_complete) begin
              settle_duration <= band_stamp_eff - start_stamp;
              settle_measured <= 1'b1;
            end
          end else begin
            in_band <= 1'b0;
          end
        end
        window_total         <= total_next;
        win_vld[window_slot] <= 1'b1;
        window_slot <= (window_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : window_slot + 1'b1;
        if (ovs_due) begin
          ready_flag <= 1'b1;
        end
        if (WIN_POW2) begin
          mean_value <= MEAN_W'(total_next >> SLOT_W);
        end
      end
      if (cmd.ovs_store) begin
        overshoot_value <= (div_quo > DIV_W'({OVS_W{1'b1}})) ? '1 : div_quo[OVS_W-1:0];
      end
      if (cmd.mean_store) begin
        mean_value <= div_quo[MEAN_W-1:0];
      end
    end
  end

  srm_divider #(
    .DIVIDEND_W(DIV_W),
    .DIVISOR_W (DIVISOR_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_a),
    .divisor (div_b),
    .quotient(div_quo),
    .done    (div_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {mean_value, overshoot_value, settle_duration, rise_duration};
      m_tuser <= {ready_flag, settle_measured, rise_measured, active_flag};
    end
  end

  always_comb begin
    sts.in_mode     = s_tuser[0];
    sts.active      = active_flag;
    sts.ovs_due     = ovs_due;
    sts.div_done    = div_done;
    sts.out_busy    = m_tvalid & ~m_tready;
    sts.mean_by_div = !WIN_POW2;
  end

endmodule

`default_nettype wire

// File: tb/sv/step_response_metrics_checker.sv
// checker for the step response metrics unit: predicts every result and compares it
`timescale 1ns / 100ps
`default_nettype none

module step_response_metrics_checker
  import srm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  input  wire logic                  pready,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // measured_speed, time_ms
  input  wire logic [IN_USER_W-1:0]  s_tuser,   // mode
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [OUT_DATA_W-1:0] m_tdata,   // rise_time, settling_time, overshoot,
                                                // mean_abs_error
  input  wire logic [OUT_USER_W-1:0] m_tuser,   // step_running, rise_found, settle_found,
                                                // metrics_ready
  output int                         failures,
  output int                         pending,
  output int                         results,
  output int                         ready_seen
);

  localparam int WIN = WINDOW_LEN_DEF;

  typedef struct packed {
    logic                 running;
    logic [TIME_W-1:0]    rise_t;
    logic                 rise_ok;
    logic [TIME_W-1:0]    settle_t;
    logic                 settle_ok;
    logic [OVS_W-1:0]     ovs;
    logic [MEAN_W-1:0]    mae;
    logic                 ready;
  } metrics_t;

  metrics_t pending_metrics[$];

  // register copies
  logic signed [SPEED_W-1:0] sp_reg;
  logic [BAND_W-1:0]         band_reg;
  logic [MIN_TIME_W-1:0]     min_reg;

  // measurement state
  logic              running, rise_on, rise_ok, in_band, settle_ok, ready;
  logic [TIME_W-1:0] start_t, rise_t0, rise_dur, band_t0, settle_dur;
  logic [OVS_W-1:0]  ovs_val;
  int                peak, slot, total;
  int                err_window[WIN];

  task automatic clear_step();
    running = 1'b0;
    rise_on = 1'b0;
    rise_ok = 1'b0;
    in_band = 1'b0;
    settle_ok = 1'b0;
    ready = 1'b0;
    start_t = '0;
    rise_t0 = '0;
    rise_dur = '0;
    band_t0 = '0;
    settle_dur = '0;
    ovs_val = '0;
    peak = 0;
    slot = 0;
    total = 0;
    foreach (err_window[i]) err_window[i] = 0;
  endtask

  task automatic advance_step_metrics(input logic start, input logic signed [SPEED_W-1:0] speed,
                                      input logic [TIME_W-1:0] stamp, output metrics_t res);
    int     sp_val, meas, asp, am, err;
    longint ovs;
    if (start) begin
      clear_step();
      running = 1'b1;
      start_t = stamp;
    end else if (running) begin
      sp_val = sp_reg;
      meas = speed;
      asp = (sp_val < 0) ? -sp_val : sp_val;
      am = (meas < 0) ? -meas : meas;
      err = (meas < sp_val) ? sp_val - meas : meas - sp_val;
      if (am > peak) peak = am;
      if (!rise_ok) begin
        if (!rise_on && 10 * am >= asp) begin
          rise_on = 1'b1;
          rise_t0 = stamp;
        end
        if (rise_on && 10 * am >= 9 * asp) begin
          rise_dur = stamp - rise_t0;
          rise_ok = 1'b1;
        end
      end
      // a zero setpoint never settles
      if (!settle_ok && asp > 0) begin
        if (100 * err <= asp * int'(band_reg)) begin
          if (!in_band) begin
            in_band = 1'b1;
            band_t0 = stamp;
          end
          if (TIME_W'(stamp - band_t0) >= TIME_W'(min_reg)) begin
            settle_dur = band_t0 - start_t;
            settle_ok = 1'b1;
          end
        end else begin
          in_band = 1'b0;
        end
      end
      total = total - err_window[slot] + err;
      err_window[slot] = err;
      slot = (slot + 1) % WIN;
      // overshoot is worked out once, on the sample that completes both measurements
      if (rise_ok && settle_ok && !ready) begin
        ovs = 0;
        if (asp > 0 && peak > asp) begin
          ovs = longint'(peak - asp) * 10000 / asp;
          if (ovs > 65535) ovs = 65535;
        end
        ovs_val = ovs[OVS_W-1:0];
        ready = 1'b1;
      end
    end
    res.running = running;
    res.rise_t = rise_dur;
    res.rise_ok = rise_ok;
    res.settle_t = settle_dur;
    res.settle_ok = settle_ok;
    res.ovs = ovs_val;
    res.mae = MEAN_W'(total / WIN);
    res.ready = ready;
  endtask

  task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 10)
        $display("[%0t] metrics mismatch on %s: expected %0d, got %0d", $realtime, name, want,
                 got);
    end
  endtask

  always @(posedge clk) begin : watch
    metrics_t want;
    if (rst) begin
      pending_metrics.delete();
      clear_step();
      sp_reg = SETPOINT_RST;
      band_reg = BAND_RST;
      min_reg = MIN_TIME_RST;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SETPOINT: sp_reg = pwdata[SPEED_W-1:0];
          REG_BAND:     band_reg = pwdata[BAND_W-1:0];
          REG_MIN_TIME: min_reg = pwdata[MIN_TIME_W-1:0];
          default: ;
        endcase
      end
      // results first: a result leaving this edge belongs to an older item
      if (m_tvalid && m_tready) begin
        results++;
        if (m_tuser[3]) ready_seen++;
        if (pending_metrics.size() == 0) begin
          failures++;
          if (failures <= 10) $display("[%0t] result transfer with nothing expected", $realtime);
        end else begin
          want = pending_metrics.pop_front();
          note_field("rise_time", want.rise_t, m_tdata[31:0]);
          note_field("settling_time", want.settle_t, m_tdata[63:32]);
          note_field("overshoot", 32'(want.ovs), 32'(m_tdata[79:64]));
          note_field("mean_abs_error", 32'(want.mae), 32'(m_tdata[95:80]));
          note_field("step_running", 32'(want.running), 32'(m_tuser[0]));
          note_field("rise_found", 32'(want.rise_ok), 32'(m_tuser[1]));
          note_field("settle_found", 32'(want.settle_ok), 32'(m_tuser[2]));
          note_field("metrics_ready", 32'(want.ready), 32'(m_tuser[3]));
        end
      end
      if (s_tvalid && s_tready) begin
        advance_step_metrics(s_tuser[0], s_tdata[15:0], s_tdata[47:16], want);
        pending_metrics.push_back(want);
      end
      pending = pending_metrics.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/sv/step_response_metrics_unit_test.sv
// top of the step response metrics unit testbench: stimulus, flow control and verdict
`timescale 1ns / 100ps
`default_nettype none

module step_response_metrics_unit_test;
  import srm_pkg::*;

  localparam int RANDOM_ITEMS = 780;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 400;

  // how the result side takes transfers
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // measured_speed, time_ms
  logic [IN_USER_W-1:0]  s_tuser = '0;   // mode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // rise_time, settling_time, overshoot, mean_abs_error
  logic [OUT_USER_W-1:0] m_tuser;        // step_running, rise_found, settle_found,
                                         // metrics_ready

  int failures, pending, results_seen, ready_seen;

  // stimulus bookkeeping
  int          items_sent = 0;
  int          steps_started = 0;
  int          settings_used = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          hold_requests = 0;
  int          cycle_count = 0;
  logic [31:0] now_ms = '0;
  int          cfg_sp = 0;

  // receiver-side state, owned by the receiver process
  int holds_served = 0;
  int hold_left = 0;
  int rx_phase = 0;

  step_response_metrics_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  step_response_metrics_checker chk (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .failures  (failures),
    .pending   (pending),
    .results   (results_seen),
    .ready_seen(ready_seen)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
      $display("step_response_metrics_unit regression: fail");
      $finish;
    end
  end

  // receiver: a long hold-off when the stimulus asks for one, otherwise the
  // stall pattern of the current phase
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:    m_tready <= 1'b1;
        RX_RANDOM:  m_tready <= 1'($urandom_range(0, 1));
        RX_PATTERN: begin
          rx_phase++;
          m_tready <= (rx_phase % 5) < 3;
        end
        RX_SLOW:    m_tready <= ($urandom_range(0, 3) == 0);
        default:    m_tready <= 1'b1;
      endcase
    end
  end

  // apb write: setup phase, access phase, then the bus goes idle
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int sp, input int band, input int min_time);
    cfg_write(REG_SETPOINT, sp & 32'hFFFF);
    cfg_write(REG_BAND, band & 32'h7F);
    cfg_write(REG_MIN_TIME, min_time & 32'hFFFF);
    cfg_sp = sp;
    settings_used++;
  endtask

  // one input transfer; in gap mode the sender idles between random bursts
  task automatic send_item(input logic mode, input logic [15:0] speed, input logic [31:0] stamp);
    if (gaps_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {stamp, speed};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic send_start(input logic [31:0] stamp);
    now_ms = stamp;
    steps_started++;
    // the speed field of a start is ignored, so it carries noise
    send_item(1'b1, 16'($urandom), stamp);
  endtask

  task automatic send_sample(input logic [15:0] speed, input int dt);
    now_ms = now_ms + dt;
    send_item(1'b0, speed, now_ms);
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] clamp_speed(input int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic int typical_setpoint();
    int mag;
    mag = $urandom_range(160, 16000);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic int sample_gap();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(11, 400);
      2:       return int'($urandom);       // big jump, wraps the timestamp
      default: return 10;
    endcase
  endfunction

  // one step: a start, then a damped response toward the setpoint with
  // overshoot and noise, sprinkled with fully random items
  task automatic run_step(input int samples);
    int aim_over, aim, cur, rate, wobble, k;
    send_start($urandom);
    aim_over = cfg_sp + cfg_sp * int'($urandom_range(0, 40)) / 100;
    rate = $urandom_range(1, 6);
    wobble = ((cfg_sp < 0) ? -cfg_sp : cfg_sp) * int'($urandom_range(0, 6)) / 100;
    cur = 0;
    for (k = 0; k < samples; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item($urandom_range(0, 7) == 0, 16'($urandom), $urandom);
      end else begin
        aim = (k < samples / 3) ? aim_over : cfg_sp;
        cur = cur + (aim - cur) * rate / 8;
        send_sample(clamp_speed(cur + int'($urandom_range(0, 2 * wobble)) - wobble),
                    sample_gap());
      end
    end
  endtask

  // one random phase: new register setting, new flow-control style, about
  // a hundred items
  task automatic run_phase(input int phase);
    int phase_end, k, sp;
    drain();
    case (phase % 6)
      1: begin
        // setpoint extremes with the widest band and no minimum time
        sp = $urandom_range(0, 1) ? -32768 : 32767;
        set_config(sp, 127, 0);
      end
      2: begin
        sp = $urandom_range(1, 40);
        set_config($urandom_range(0, 1) ? -sp : sp, 100, 0);
      end
      3: set_config(typical_setpoint(), 0, $urandom_range(0, 30));
      4: set_config(typical_setpoint(), $urandom_range(2, 15), 65535);
      5: set_config(0, $urandom_range(0, 127), $urandom_range(0, 100));
      default: set_config(typical_setpoint(), $urandom_range(2, 15), $urandom_range(0, 120));
    endcase
    gaps_on = (phase % 3 != 0);
    rx_mode = rx_mode_t'(phase % 4);
    // receiver holds off while the sender keeps pushing, so the unit backs up
    if (phase % 4 == 3) hold_requests++;
    phase_end = items_sent + 100;
    // the step from the previous phase goes on under the new setting
    for (k = 0; k < 3; k++)
      send_sample(clamp_speed(cfg_sp + int'($urandom_range(0, 40)) - 20), 10);
    while (items_sent < phase_end) run_step($urandom_range(15, 60));
  endtask

  initial begin : stimulus
    int random_end, phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // samples before any start are ignored
    send_item(1'b0, 16'h7FFF, 32'hFFFF_FFFF);
    send_item(1'b0, 16'h8000, 32'h0000_0000);
    drain();
    set_config(1600, 5, 30);

    // full step across the timestamp wrap, exact threshold and band edges
    send_start(32'hFFFF_FFF0);
    send_sample(16'd0, 10);
    send_sample(16'd160, 10);      // exactly 10 percent: rise begins
    send_sample(16'd1439, 10);     // just short of 90 percent
    send_sample(16'd1440, 10);     // 90 percent: rise found
    send_sample(16'd1900, 10);     // overshoot, out of band
    send_sample(16'd1680, 10);     // on the band edge
    send_sample(16'd1600, 29);     // one ms short of the minimum time
    send_sample(16'd1520, 1);      // settled, metrics ready
    send_sample(16'h8000, 10);     // after ready the peak moves, overshoot stays
    send_sample(16'h7FFF, 10);
    send_start(32'h0000_1000);     // restart clears everything

    // zero setpoint: rise in one sample, never settles
    drain();
    set_config(0, 127, 0);
    send_start(32'h0000_2000);
    send_sample(16'd5, 10);
    send_sample(-16'sd5, 10);

    // most negative setpoint, band of 100 percent, longest minimum time
    drain();
    set_config(-32768, 100, 65535);
    send_start(32'h8000_0000);
    send_sample(-16'sd3276, 10);
    send_sample(-16'sd3277, 10);
    send_sample(-16'sd29492, 10);
    send_sample(16'h8000, 65535);

    // overshoot that saturates
    drain();
    set_config(1, 100, 0);
    send_start(32'h0000_0100);
    send_sample(16'h7FFF, 10);
    send_sample(16'd1, 10);

    // setpoint changed in the middle of a step
    drain();
    set_config(800, 10, 20);
    send_sample(16'd790, 10);

    random_end = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_end) begin
      run_phase(phase);
      phase++;
    end

    drain();
    rx_mode = RX_OPEN;
    repeat (60) @(posedge clk);
    $display("ran %0d items in %0d steps over %0d register settings", items_sent,
             steps_started, settings_used);
    $display("checked %0d results, %0d of them with metrics ready", results_seen, ready_seen);
    if (failures == 0 && pending == 0) begin
      $display("step_response_metrics_unit regression: pass");
    end else begin
      $display("step_response_metrics_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
